// File: rtl/itda_pkg.sv
package itda_pkg;

   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 7;
   localparam int NUM_DIGITS = 10;
   localparam int BIT_CNT_W  = $clog2(VALUE_W);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'd57;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   // Commands to the BCD shift register.
   typedef struct packed {
      logic clear;
      logic shift_bit;
      logic bit_in;
      logic shift_digit;
   } bcd_ctrl_type;

endpackage

// File: rtl/itda_bcd.sv
module itda_bcd
   import itda_pkg::*;
(
   input  logic         clock,
   input  bcd_ctrl_type ctrl,
   output logic [3:0]   top_digit
);

   logic [3:0] digits_ff [NUM_DIGITS];
   logic [3:0] digits_in [NUM_DIGITS];
   logic [3:0] adj       [NUM_DIGITS];

   // Double dabble: every digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         digits_in[i] = digits_ff[i];
         if (ctrl.clear) begin
            digits_in[i] = 4'd0;
         end else if (ctrl.shift_bit) begin
            if (i == 0) begin
               digits_in[i] = {adj[i][2:0], ctrl.bit_in};
            end else begin
               digits_in[i] = {adj[i][2:0], adj[i-1][3]};
            end
         end else if (ctrl.shift_digit) begin
            digits_in[i] = (i == 0) ? 4'd0 : digits_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         digits_ff[i] <= digits_in[i];
      end
   end

   assign top_digit = digits_ff[NUM_DIGITS-1];

endmodule

// File: rtl/int_to_decimal_ascii.sv
// Converts one signed 32-bit word to its decimal ASCII text, most significant
// character first, one rsp word per character, with a leading '-' for negative
// values and rsp_last_char set on the final digit. An accepted word is negated
// if needed, then shifted one bit per cycle through a double-dabble BCD register,
// then leading zero digits are dropped at one per cycle (up to 9), then each
// character leaves through the output register at one per cycle while
// rsp_ready is high. The next word is accepted once the final character sits
// in the output register.
module int_to_decimal_ascii
   import itda_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic        [CHAR_W-1:0]  rsp_character,
   output logic                      rsp_last_char
);

   state_type              state_ff, state_in;
   logic [VALUE_W-1:0]     mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [BIT_CNT_W-1:0]   bitcnt_ff, bitcnt_in;
   logic [DIG_CNT_W-1:0]   rem_ff, rem_in;
   logic                   started_ff, started_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_character_ff, rsp_character_in;
   logic                   rsp_last_char_ff, rsp_last_char_in;

   bcd_ctrl_type           bcd_ctrl;
   logic [3:0]             top_digit;
   logic                   accept;
   logic                   out_free;
   logic                   load_out;
   logic                   skip_zero;
   logic [CHAR_W-1:0]      load_char;
   logic                   load_last;

   itda_bcd u_bcd (
      .clock     (clock),
      .ctrl      (bcd_ctrl),
      .top_digit (top_digit)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign skip_zero = !started_ff && (top_digit == 4'd0) && (rem_ff > DIG_CNT_W'(1));

   // Control outputs.
   always_comb begin
      req_ready            = 1'b0;
      bcd_ctrl             = '0;
      bcd_ctrl.bit_in      = mag_ff[VALUE_W-1];
      load_out             = 1'b0;
      load_char            = ASCII_ZERO + {3'b000, top_digit};
      load_last            = (rem_ff == DIG_CNT_W'(1));
      unique case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            bcd_ctrl.clear = 1'b1;
         end
         ST_CONV: begin
            bcd_ctrl.shift_bit = 1'b1;
         end
         ST_SIGN: begin
            load_out  = out_free;
            load_char = ASCII_MINUS;
            load_last = 1'b0;
         end
         ST_DIGITS: begin
            if (skip_zero) begin
               bcd_ctrl.shift_digit = 1'b1;
            end else if (out_free) begin
               load_out             = 1'b1;
               bcd_ctrl.shift_digit = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Next state and datapath.
   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      bitcnt_in  = bitcnt_ff;
      rem_in     = rem_ff;
      started_in = started_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in    = req_value[VALUE_W-1];
               mag_in    = req_value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(req_value))
                                                : $unsigned(req_value);
               bitcnt_in = '0;
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            mag_in    = {mag_ff[VALUE_W-2:0], 1'b0};
            bitcnt_in = bitcnt_ff + BIT_CNT_W'(1);
            if (bitcnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               rem_in     = DIG_CNT_W'(NUM_DIGITS);
               started_in = 1'b0;
               state_in   = neg_ff ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (skip_zero) begin
               rem_in = rem_ff - DIG_CNT_W'(1);
            end else if (out_free) begin
               rem_in     = rem_ff - DIG_CNT_W'(1);
               started_in = 1'b1;
               if (rem_ff == DIG_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_character_in = rsp_character_ff;
      rsp_last_char_in = rsp_last_char_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      if (load_out) begin
         rsp_valid_in     = 1'b1;
         rsp_character_in = load_char;
         rsp_last_char_in = load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      neg_ff           <= neg_in;
      bitcnt_ff        <= bitcnt_in;
      rem_ff           <= rem_in;
      started_ff       <= started_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_char_ff <= rsp_last_char_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last_char = rsp_last_char_ff;

   // Every character is a minus sign or a decimal digit.
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == ASCII_MINUS) ||
                    ((rsp_character >= ASCII_ZERO) && (rsp_character <= ASCII_NINE)))
      else $error("rsp_character is neither a digit nor a minus sign");

   // The sign is never the final character.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_character == ASCII_MINUS)) |-> !rsp_last_char)
      else $error("minus sign flagged as last character");

   // An accepted word always starts a conversion.
   a_accept_conv: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CONV) && (bitcnt_ff == '0))
      else $error("accepted word did not start a conversion");

   // Digits leave only after all leading zeros are gone.
   a_first_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS && load_out && !started_ff && rem_ff > DIG_CNT_W'(1))
         |-> (top_digit != 4'd0))
      else $error("leading zero emitted");

endmodule
